[hdl/sccb_pkg.sv]
package sccb_pkg;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_PROBE = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [3:0] OP_END       = 4'd0;
  localparam logic [3:0] OP_START     = 4'd1;
  localparam logic [3:0] OP_STOP      = 4'd2;
  localparam logic [3:0] OP_WAIT      = 4'd3;
  localparam logic [3:0] OP_NOACK     = 4'd4;
  localparam logic [3:0] OP_SEND_DEV  = 4'd5;
  localparam logic [3:0] OP_SEND_DEVR = 4'd6;
  localparam logic [3:0] OP_SEND_REG  = 4'd7;
  localparam logic [3:0] OP_SEND_DAT  = 4'd8;
  localparam logic [3:0] OP_RECV      = 4'd9;

  localparam logic [3:0] READ_ABORT_POS = 4'd12;
  localparam int         PHASE_ITERS    = 4;

  localparam logic       REG_HALF_PERIOD = 1'b0;
  localparam logic       REG_DEVICE_ADDR = 1'b1;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd2250;
  localparam logic [7:0]  DEVICE_ADDR_RESET = 8'h42;
  localparam logic [7:0]  NACK_READ_BYTE    = 8'hFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] probe_address;
    logic       sda_sample;
  } tick_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nack_seen;
    logic [7:0] read_byte;
  } tick_out_t;

  typedef struct packed {
    logic [2:0]  sub;
    logic [3:0]  pos;
    logic [15:0] delay;
    logic [3:0]  bits;
    logic [7:0]  shift;
    logic [7:0]  recv;
    logic [1:0]  cmd;
    logic [7:0]  reg_addr;
    logic [7:0]  data;
    logic        nack;
    logic        scl;
    logic        sda;
  } seq_state_t;

  typedef struct packed {
    seq_state_t st;
    logic       halt;
    logic       fin;
  } phase_t;

  function automatic logic [3:0] script_op(logic [1:0] cmd, logic [3:0] pos);
    logic [3:0] op;
    op = OP_END;
    unique case (cmd)
      CMD_PROBE: begin
        case (pos)
          4'd0: op = OP_START;
          4'd1: op = OP_SEND_DAT;
          4'd2: op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      CMD_WRITE: begin
        case (pos)
          4'd0: op = OP_START;
          4'd1: op = OP_SEND_DEV;
          4'd2: op = OP_SEND_REG;
          4'd3: op = OP_SEND_DAT;
          4'd4: op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      CMD_READ: begin
        case (pos)
          4'd0:  op = OP_START;
          4'd1:  op = OP_SEND_DEV;
          4'd2:  op = OP_WAIT;
          4'd3:  op = OP_SEND_REG;
          4'd4:  op = OP_WAIT;
          4'd5:  op = OP_STOP;
          4'd6:  op = OP_WAIT;
          4'd7:  op = OP_START;
          4'd8:  op = OP_SEND_DEVR;
          4'd9:  op = OP_WAIT;
          4'd10: op = OP_RECV;
          4'd11: op = OP_NOACK;
          4'd12: op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      default: op = OP_END;
    endcase
    return op;
  endfunction

  // One bus action; halt marks the start of a timed phase or the end of the script.
  function automatic phase_t phase_step(seq_state_t s, logic sda_in, logic [15:0] half,
                                        logic [7:0] dev);
    phase_t     r;
    logic [3:0] op;
    logic       hold;
    logic       opdone;
    logic       abort_rd;
    logic [3:0] bits_inc;
    r        = '{st: s, halt: 1'b0, fin: 1'b0};
    hold     = 1'b0;
    opdone   = 1'b0;
    abort_rd = 1'b0;
    bits_inc = s.bits + 4'd1;
    op       = script_op(s.cmd, s.pos);
    case (op)
      OP_START: begin
        case (s.sub)
          3'd0: begin r.st.sda = 1'b1; r.st.scl = 1'b1; hold = 1'b1; end
          3'd1: begin r.st.sda = 1'b0; hold = 1'b1; end
          3'd2: begin r.st.scl = 1'b0; hold = 1'b1; end
          default: opdone = 1'b1;
        endcase
      end
      OP_STOP: begin
        case (s.sub)
          3'd0: begin r.st.sda = 1'b0; hold = 1'b1; end
          3'd1: begin r.st.scl = 1'b1; hold = 1'b1; end
          3'd2: begin r.st.sda = 1'b1; hold = 1'b1; end
          default: opdone = 1'b1;
        endcase
      end
      OP_WAIT: begin
        if (s.sub == 3'd0) hold = 1'b1;
        else opdone = 1'b1;
      end
      OP_NOACK: begin
        case (s.sub)
          3'd0: hold = 1'b1;
          3'd1: begin r.st.sda = 1'b1; r.st.scl = 1'b1; hold = 1'b1; end
          3'd2: begin r.st.scl = 1'b0; hold = 1'b1; end
          3'd3: begin r.st.sda = 1'b0; hold = 1'b1; end
          default: opdone = 1'b1;
        endcase
      end
      OP_SEND_DEV, OP_SEND_DEVR, OP_SEND_REG, OP_SEND_DAT: begin
        case (s.sub)
          3'd0: begin
            case (op)
              OP_SEND_DEV:  r.st.shift = dev;
              OP_SEND_DEVR: r.st.shift = dev | 8'h01;
              OP_SEND_REG:  r.st.shift = s.reg_addr;
              default:      r.st.shift = s.data;
            endcase
            r.st.bits = 4'd0;
            r.st.sub  = 3'd1;
          end
          3'd1: begin
            r.st.sda   = s.shift[7];
            r.st.shift = {s.shift[6:0], 1'b0};
            hold       = 1'b1;
          end
          3'd2: begin r.st.scl = 1'b1; hold = 1'b1; end
          3'd3: begin
            r.st.scl  = 1'b0;
            r.st.bits = bits_inc;
            r.st.sub  = (bits_inc < 4'd8) ? 3'd1 : 3'd4;
          end
          3'd4: begin r.st.sda = 1'b1; hold = 1'b1; end
          3'd5: begin r.st.scl = 1'b1; hold = 1'b1; end
          default: begin
            if (sda_in) begin
              r.st.nack = 1'b1;
              abort_rd  = (s.cmd == CMD_READ);
            end
            r.st.scl = 1'b0;
            opdone   = 1'b1;
          end
        endcase
      end
      OP_RECV: begin
        case (s.sub)
          3'd0: begin
            r.st.sda  = 1'b1;
            r.st.recv = 8'd0;
            r.st.bits = 4'd0;
            r.st.sub  = 3'd1;
          end
          3'd1: hold = 1'b1;
          3'd2: begin
            r.st.scl  = 1'b1;
            r.st.recv = {s.recv[6:0], sda_in};
            hold      = 1'b1;
          end
          default: begin
            r.st.scl  = 1'b0;
            r.st.bits = bits_inc;
            if (bits_inc < 4'd8) r.st.sub = 3'd1;
            else opdone = 1'b1;
          end
        endcase
      end
      default: begin
        r.fin  = 1'b1;
        r.halt = 1'b1;
      end
    endcase
    if (hold) begin
      r.st.delay = (half == 16'd0) ? 16'd0 : half - 16'd1;
      r.st.sub   = s.sub + 3'd1;
      r.halt     = 1'b1;
    end else if (abort_rd) begin
      r.st.pos = READ_ABORT_POS;
      r.st.sub = 3'd0;
    end else if (opdone) begin
      r.st.pos = s.pos + 4'd1;
      r.st.sub = 3'd0;
    end
    return r;
  endfunction

endpackage

[hdl/sccb_seq.sv]
module sccb_seq import sccb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  tick_in_t    tick,
  output tick_out_t   result
);

  logic [15:0] half_period;
  logic [7:0]  device_addr;
  seq_state_t  state;
  seq_state_t  state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
      device_addr <= DEVICE_ADDR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: half_period <= cfg_data;
        REG_DEVICE_ADDR: device_addr <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    seq_state_t cur;
    phase_t     p;
    logic       run;
    logic       halted;
    logic       fin;
    cur    = state;
    p      = '0;
    run    = 1'b0;
    halted = 1'b0;
    fin    = 1'b0;
    result = '0;
    if (state.cmd == CMD_NONE) begin
      if (tick.cmd != CMD_NONE) begin
        cur.cmd      = tick.cmd;
        cur.reg_addr = tick.register_address;
        cur.data     = (tick.cmd == CMD_PROBE) ? tick.probe_address : tick.write_data;
        cur.pos      = 4'd0;
        cur.sub      = 3'd0;
        cur.bits     = 4'd0;
        cur.nack     = 1'b0;
        cur.recv     = 8'd0;
        result.busy_res = 1'b1;
        run          = 1'b1;
      end
    end else begin
      result.busy_res = 1'b1;
      if (state.delay != 16'd0) cur.delay = state.delay - 16'd1;
      else run = 1'b1;
    end
    if (run) begin
      for (int i = 0; i < PHASE_ITERS; i++) begin
        if (!halted) begin
          p      = phase_step(cur, tick.sda_sample, half_period, device_addr);
          cur    = p.st;
          halted = p.halt;
          fin    = p.fin;
        end
      end
    end
    if (fin) begin
      result.done_res  = 1'b1;
      result.nack_seen = cur.nack;
      if (cur.cmd == CMD_READ) result.read_byte = cur.nack ? NACK_READ_BYTE : cur.recv;
      cur.cmd   = CMD_NONE;
      cur.pos   = 4'd0;
      cur.sub   = 3'd0;
      cur.delay = 16'd0;
    end
    result.scl_level = cur.scl;
    result.sda_level = cur.sda;
    state_next       = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{scl: 1'b1, sda: 1'b1, default: '0};
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

[hdl/sccb_register_master.sv]
// SCCB register master at pin level. Each input transaction is one bus tick carrying a command
// and the sampled SDA level; each output transaction gives the SCL/SDA drive, busy, a done
// pulse, NACK and the read byte for that tick. One tick is processed per clock cycle unless the
// output is stalled by out_ready; a tick passes through the input register, then the result
// register, and the rate is set by the sequencer state register, which each tick updates once.
module sccb_register_master import sccb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  register_address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  probe_address,
  input  logic        sda_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic        nack_seen,
  output logic [7:0]  read_byte
);

  logic      in_full;
  tick_in_t  in_item;
  logic      advance;
  tick_out_t seq_result;
  tick_out_t out_item;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item <= '{cmd: cmd, register_address: register_address, write_data: write_data,
                   probe_address: probe_address, sda_sample: sda_sample};
    end
  end

  sccb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance),
    .tick      (in_item),
    .result    (seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= seq_result;
    end
  end

  assign scl_level = out_item.scl_level;
  assign sda_level = out_item.sda_level;
  assign busy_res  = out_item.busy_res;
  assign done_res  = out_item.done_res;
  assign nack_seen = out_item.nack_seen;
  assign read_byte = out_item.read_byte;

endmodule

[hdl/sccb_check.sv]
module sccb_check (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic       done_res,
  input logic       nack_seen,
  input logic [7:0] read_byte
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_byte) && $stable(done_res))
    else $error("stalled result changed");

  a_fields_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !nack_seen && read_byte == 8'd0)
    else $error("nack or read byte outside done");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> busy_res)
    else $error("done without busy");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> scl_level && sda_level)
    else $error("bus lines not released while idle");

endmodule

bind sccb_register_master sccb_check u_sccb_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .scl_level (scl_level),
  .sda_level (sda_level),
  .busy_res  (busy_res),
  .done_res  (done_res),
  .nack_seen (nack_seen),
  .read_byte (read_byte)
);

[sim/tb.sv]
module tb;
  import sccb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1_000_000;
  localparam int NUM_PLAN = 13;
  localparam int RANDOM_PER_PHASE = 60;

  localparam logic [1:0] ACK_ALL = 2'd0;
  localparam logic [1:0] NACK_ALL = 2'd1;
  localparam logic [1:0] ACK_RANDOM = 2'd2;

  // op lists, position 0 in the low nibble
  localparam logic [63:0] PROBE_SCRIPT = {52'd0, OP_STOP, OP_SEND_DAT, OP_START};
  localparam logic [63:0] WRITE_SCRIPT =
    {44'd0, OP_STOP, OP_SEND_DAT, OP_SEND_REG, OP_SEND_DEV, OP_START};
  localparam logic [63:0] READ_SCRIPT =
    {12'd0, OP_STOP, OP_NOACK, OP_RECV, OP_WAIT, OP_SEND_DEVR, OP_START, OP_WAIT, OP_STOP,
     OP_WAIT, OP_SEND_REG, OP_WAIT, OP_SEND_DEV, OP_START};

  typedef struct packed {
    logic [15:0] half;
    logic [7:0]  dev;
    logic [15:0] run_half;
    logic [1:0]  op;
    logic [7:0]  reg_addr;
    logic [7:0]  wdata;
    logic [7:0]  paddr;
    logic [1:0]  ack;
    logic [7:0]  rd;
    logic        typed;
    logic        nack;
    logic [7:0]  rb;
  } bus_case_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [7:0]  register_address;
  logic [7:0]  write_data;
  logic [7:0]  probe_address;
  logic        sda_sample;
  logic        out_valid;
  logic        out_ready;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic        nack_seen;
  logic [7:0]  read_byte;

  sccb_register_master DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .register_address(register_address),
    .write_data(write_data),
    .probe_address(probe_address),
    .sda_sample(sda_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .scl_level(scl_level),
    .sda_level(sda_level),
    .busy_res(busy_res),
    .done_res(done_res),
    .nack_seen(nack_seen),
    .read_byte(read_byte)
  );

  // bus master state as the predictor sees it
  logic [15:0] p_half;
  logic [7:0]  p_dev;
  logic [5:0]  p_sub;
  logic [3:0]  p_pos;
  logic [15:0] p_delay;
  logic [3:0]  p_bits;
  logic [7:0]  p_shift;
  logic [7:0]  p_recv;
  logic [1:0]  p_cmd;
  logic [7:0]  p_reg;
  logic [7:0]  p_data;
  logic        p_nack;
  logic        p_scl;
  logic        p_sda;

  logic [1:0]  dev_ack_mode;
  logic [7:0]  dev_read_byte;

  tick_out_t   pending_ticks [$];
  bus_case_t   plan [NUM_PLAN];
  int          gap_pct;
  int          stall_pct;
  bit          park_request;
  int          park_left;
  int          errors;
  int          cycles;
  int          ticks_sent;
  int          results_checked;
  int          done_count [4];
  int          nack_count;
  tick_out_t   got_res;
  tick_out_t   want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] op_at(logic [1:0] c, logic [3:0] p);
    logic [63:0] s;
    case (c)
      CMD_PROBE: s = PROBE_SCRIPT;
      CMD_WRITE: s = WRITE_SCRIPT;
      CMD_READ:  s = READ_SCRIPT;
      default:   s = PROBE_SCRIPT;
    endcase
    return s[{p, 2'b00} +: 4];
  endfunction

  function automatic bit is_send(logic [3:0] op);
    return op == OP_SEND_DEV || op == OP_SEND_DEVR || op == OP_SEND_REG || op == OP_SEND_DAT;
  endfunction

  // run bus actions until a timed phase starts; return 1 when the op list ends
  function automatic bit advance_bus(logic sda_in);
    logic [3:0] op;
    logic [5:0] sub;
    bit hold;
    bit step_done;
    bit abort;
    bit running;
    bit finished;
    int g;
    running = 1'b1;
    finished = 1'b1;
    for (g = 0; g < 64 && running; g++) begin
      op = op_at(p_cmd, p_pos);
      sub = p_sub;
      hold = 1'b0;
      step_done = 1'b0;
      abort = 1'b0;
      if (op == OP_START) begin
        case (sub)
          0: begin p_sda = 1'b1; p_scl = 1'b1; hold = 1'b1; end
          1: begin p_sda = 1'b0; hold = 1'b1; end
          2: begin p_scl = 1'b0; hold = 1'b1; end
          default: step_done = 1'b1;
        endcase
      end else if (op == OP_STOP) begin
        case (sub)
          0: begin p_sda = 1'b0; hold = 1'b1; end
          1: begin p_scl = 1'b1; hold = 1'b1; end
          2: begin p_sda = 1'b1; hold = 1'b1; end
          default: step_done = 1'b1;
        endcase
      end else if (op == OP_WAIT) begin
        if (sub == 0) hold = 1'b1;
        else step_done = 1'b1;
      end else if (op == OP_NOACK) begin
        case (sub)
          0: hold = 1'b1;
          1: begin p_sda = 1'b1; p_scl = 1'b1; hold = 1'b1; end
          2: begin p_scl = 1'b0; hold = 1'b1; end
          3: begin p_sda = 1'b0; hold = 1'b1; end
          default: step_done = 1'b1;
        endcase
      end else if (is_send(op)) begin
        case (sub)
          0: begin
            if (op == OP_SEND_DEV) p_shift = p_dev;
            else if (op == OP_SEND_DEVR) p_shift = p_dev | 8'h01;
            else if (op == OP_SEND_REG) p_shift = p_reg;
            else p_shift = p_data;
            p_bits = 4'd0;
            p_sub = 6'd1;
          end
          1: begin
            p_sda = p_shift[7];
            p_shift = {p_shift[6:0], 1'b0};
            hold = 1'b1;
          end
          2: begin p_scl = 1'b1; hold = 1'b1; end
          3: begin
            p_scl = 1'b0;
            p_bits = p_bits + 4'd1;
            p_sub = (p_bits < 4'd8) ? 6'd1 : 6'd4;
          end
          4: begin p_sda = 1'b1; hold = 1'b1; end
          5: begin p_scl = 1'b1; hold = 1'b1; end
          default: begin
            if (sda_in) begin
              p_nack = 1'b1;
              abort = (p_cmd == CMD_READ);
            end
            p_scl = 1'b0;
            step_done = 1'b1;
          end
        endcase
      end else if (op == OP_RECV) begin
        case (sub)
          0: begin
            p_sda = 1'b1;
            p_recv = 8'd0;
            p_bits = 4'd0;
            p_sub = 6'd1;
          end
          1: hold = 1'b1;
          2: begin
            p_scl = 1'b1;
            p_recv = {p_recv[6:0], sda_in};
            hold = 1'b1;
          end
          default: begin
            p_scl = 1'b0;
            p_bits = p_bits + 4'd1;
            if (p_bits < 4'd8) p_sub = 6'd1;
            else step_done = 1'b1;
          end
        endcase
      end else begin
        running = 1'b0;
      end
      if (running) begin
        if (hold) begin
          p_delay = (p_half == 16'd0) ? 16'd0 : p_half - 16'd1;
          p_sub = sub + 6'd1;
          finished = 1'b0;
          running = 1'b0;
        end else if (abort) begin
          p_pos = READ_ABORT_POS;
          p_sub = 6'd0;
        end else if (step_done) begin
          p_pos = p_pos + 4'd1;
          p_sub = 6'd0;
        end
      end
    end
    return finished;
  endfunction

  function automatic tick_out_t step_bus_master(tick_in_t t);
    tick_out_t r;
    bit fin;
    bit busy;
    r = '0;
    fin = 1'b0;
    busy = 1'b0;
    if (p_cmd == CMD_NONE) begin
      if (t.cmd != CMD_NONE) begin
        p_cmd = t.cmd;
        p_reg = t.register_address;
        p_data = (t.cmd == CMD_PROBE) ? t.probe_address : t.write_data;
        p_pos = 4'd0;
        p_sub = 6'd0;
        p_bits = 4'd0;
        p_nack = 1'b0;
        p_recv = 8'd0;
        busy = 1'b1;
        fin = advance_bus(t.sda_sample);
      end
    end else begin
      busy = 1'b1;
      if (p_delay != 16'd0) p_delay = p_delay - 16'd1;
      else fin = advance_bus(t.sda_sample);
    end
    if (fin) begin
      r.nack_seen = p_nack;
      if (p_cmd == CMD_READ) r.read_byte = p_nack ? NACK_READ_BYTE : p_recv;
      done_count[p_cmd]++;
      if (p_nack) nack_count++;
      p_cmd = CMD_NONE;
      p_pos = 4'd0;
      p_sub = 6'd0;
      p_delay = 16'd0;
    end
    r.scl_level = p_scl;
    r.sda_level = p_sda;
    r.busy_res = busy;
    r.done_res = fin;
    return r;
  endfunction

  // target device: acks as told and returns its byte MSB first
  function automatic logic device_sda();
    logic [3:0] op;
    op = op_at(p_cmd, p_pos);
    if (p_cmd != CMD_NONE && p_delay == 16'd0) begin
      if (is_send(op) && p_sub == 6'd6) begin
        case (dev_ack_mode)
          ACK_ALL:  return 1'b0;
          NACK_ALL: return 1'b1;
          default:  return $urandom_range(0, 9) == 0;
        endcase
      end
      if (op == OP_RECV && p_sub == 6'd2) return dev_read_byte[7 - p_bits];
    end
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic tick_in_t random_tick(logic [1:0] c);
    tick_in_t t;
    t.cmd = c;
    t.register_address = 8'($urandom_range(0, 255));
    t.write_data = 8'($urandom_range(0, 255));
    t.probe_address = 8'($urandom_range(0, 255));
    t.sda_sample = 1'b0;
    return t;
  endfunction

  task automatic send_bus_tick(input tick_in_t t, input bit typed, input tick_out_t typed_res);
    tick_out_t res;
    t.sda_sample = device_sda();
    res = step_bus_master(t);
    if (typed && (res.done_res || !res.busy_res)) res = typed_res;
    pending_ticks.push_back(res);
    ticks_sent++;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= t.cmd;
    register_address <= t.register_address;
    write_data <= t.write_data;
    probe_address <= t.probe_address;
    sda_sample <= t.sda_sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_ticks.size() != 0);
  endtask

  task automatic set_bus_config(input logic [15:0] half, input logic [7:0] dev);
    cfg_write <= 1'b1;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data <= half;
    @(negedge clk);
    cfg_index <= REG_DEVICE_ADDR;
    cfg_data <= {8'd0, dev};
    @(negedge clk);
    cfg_write <= 1'b0;
    p_half = half;
    p_dev = dev;
  endtask

  initial begin
    out_ready = 1'b0;
    park_left = 0;
    forever begin
      @(negedge clk);
      if (park_left != 0) begin
        out_ready <= 1'b0;
        park_left--;
      end else if (park_request) begin
        park_request = 1'b0;
        park_left = 80;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_res = {scl_level, sda_level, busy_res, done_res, nack_seen, read_byte};
      results_checked++;
      if (pending_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result scl=%b sda=%b busy=%b done=%b nack=%b rd=%02h",
                 $time, got_res.scl_level, got_res.sda_level, got_res.busy_res,
                 got_res.done_res, got_res.nack_seen, got_res.read_byte);
      end else begin
        want_res = pending_ticks.pop_front();
        if (got_res !== want_res) begin
          errors++;
          $display("%0t: tick %0d expected %b%b%b%b%b %02h, got %b%b%b%b%b %02h",
                   $time, results_checked, want_res.scl_level, want_res.sda_level,
                   want_res.busy_res, want_res.done_res, want_res.nack_seen,
                   want_res.read_byte, got_res.scl_level, got_res.sda_level,
                   got_res.busy_res, got_res.done_res, got_res.nack_seen, got_res.read_byte);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tick_in_t   t;
    tick_out_t  typed_res;
    logic [1:0] c;
    int         i;
    int         n;
    int         ph;
    int         k;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = CMD_NONE;
    register_address = 8'd0;
    write_data = 8'd0;
    probe_address = 8'd0;
    sda_sample = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_HALF_PERIOD;
    cfg_data = 16'd0;
    gap_pct = 27;
    stall_pct = 55;
    park_request = 1'b0;
    errors = 0;
    cycles = 0;
    ticks_sent = 0;
    results_checked = 0;
    nack_count = 0;
    for (i = 0; i < 4; i++) done_count[i] = 0;
    p_half = HALF_PERIOD_RESET;
    p_dev = DEVICE_ADDR_RESET;
    p_sub = 6'd0;
    p_pos = 4'd0;
    p_delay = 16'd0;
    p_bits = 4'd0;
    p_shift = 8'd0;
    p_recv = 8'd0;
    p_cmd = CMD_NONE;
    p_reg = 8'd0;
    p_data = 8'd0;
    p_nack = 1'b0;
    p_scl = 1'b1;
    p_sda = 1'b1;
    dev_ack_mode = ACK_ALL;
    dev_read_byte = 8'd0;

    plan[0]  = '{HALF_PERIOD_RESET, DEVICE_ADDR_RESET, HALF_PERIOD_RESET, CMD_NONE,
                 8'h00, 8'h00, 8'h00, ACK_ALL, 8'h00, 1'b1, 1'b0, 8'h00};
    plan[1]  = '{16'd1, DEVICE_ADDR_RESET, 16'd1, CMD_WRITE,
                 8'h00, 8'hFF, 8'h00, ACK_ALL, 8'h00, 1'b1, 1'b0, 8'h00};
    plan[2]  = '{16'd1, 8'h42, 16'd1, CMD_PROBE,
                 8'hFF, 8'h00, 8'h80, ACK_ALL, 8'h00, 1'b1, 1'b0, 8'h00};
    plan[3]  = '{16'd0, 8'hFF, 16'd0, CMD_READ,
                 8'hFF, 8'h00, 8'h00, ACK_ALL, 8'hA5, 1'b1, 1'b0, 8'hA5};
    plan[4]  = '{16'd1, 8'h00, 16'd1, CMD_READ,
                 8'h00, 8'h00, 8'h00, NACK_ALL, 8'h3C, 1'b1, 1'b1, NACK_READ_BYTE};
    plan[5]  = '{16'd1, 8'h42, 16'd1, CMD_WRITE,
                 8'h7E, 8'h81, 8'h00, NACK_ALL, 8'h00, 1'b1, 1'b1, 8'h00};
    plan[6]  = '{16'd2, 8'h42, 16'd2, CMD_PROBE,
                 8'h00, 8'h00, 8'hFF, NACK_ALL, 8'h00, 1'b1, 1'b1, 8'h00};
    plan[7]  = '{16'd1, 8'h43, 16'd1, CMD_READ,
                 8'h01, 8'h00, 8'h00, ACK_ALL, 8'h00, 1'b1, 1'b0, 8'h00};
    plan[8]  = '{16'd1, 8'hFE, 16'd1, CMD_READ,
                 8'h80, 8'h00, 8'h00, ACK_ALL, 8'hFF, 1'b1, 1'b0, 8'hFF};
    plan[9]  = '{16'd1, 8'hFE, 16'd1, CMD_READ,
                 8'h55, 8'h00, 8'h00, ACK_RANDOM, 8'h5A, 1'b0, 1'b0, 8'h00};
    plan[10] = '{16'd1, 8'hFE, 16'd1, CMD_NONE,
                 8'h00, 8'h00, 8'h00, ACK_ALL, 8'h00, 1'b1, 1'b0, 8'h00};
    plan[11] = '{16'd0, 8'h42, 16'd0, CMD_WRITE,
                 8'hFF, 8'h00, 8'hFF, ACK_RANDOM, 8'h00, 1'b0, 1'b0, 8'h00};
    plan[12] = '{16'd0, 8'h42, 16'd0, CMD_PROBE,
                 8'h00, 8'h5A, 8'h00, ACK_RANDOM, 8'h00, 1'b0, 1'b0, 8'h00};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < NUM_PLAN; i++) begin
      if (plan[i].half != p_half || plan[i].dev != p_dev) begin
        wait_drained();
        set_bus_config(plan[i].half, plan[i].dev);
      end
      dev_ack_mode = plan[i].ack;
      dev_read_byte = plan[i].rd;
      typed_res = {2'b11, plan[i].op != CMD_NONE, plan[i].op != CMD_NONE,
                   plan[i].nack, plan[i].rb};
      t = {plan[i].op, plan[i].reg_addr, plan[i].wdata, plan[i].paddr, 1'b0};
      send_bus_tick(t, plan[i].typed, typed_res);
      if (plan[i].run_half != plan[i].half) begin
        wait_drained();
        set_bus_config(plan[i].run_half, plan[i].dev);
      end
      while (p_cmd != CMD_NONE) begin
        c = 2'($urandom_range(0, 3));
        send_bus_tick(random_tick(c), plan[i].typed, typed_res);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          gap_pct = 27;
          stall_pct = 55;
          set_bus_config(16'd1, 8'($urandom_range(0, 255)));
        end
        1: begin
          gap_pct = 55;
          stall_pct = 27;
          set_bus_config(16'd0, 8'hFF);
        end
        default: begin
          gap_pct = 0;
          stall_pct = 0;
          set_bus_config(16'($urandom_range(1, 2)), 8'h00);
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p_cmd == CMD_NONE) begin
          dev_read_byte = 8'($urandom_range(0, 255));
          k = $urandom_range(0, 9);
          dev_ack_mode = (k == 0) ? ACK_ALL : (k == 1) ? NACK_ALL : ACK_RANDOM;
          c = ($urandom_range(0, 9) < 7) ? 2'($urandom_range(1, 3)) : CMD_NONE;
        end else begin
          c = 2'($urandom_range(0, 3));
        end
        send_bus_tick(random_tick(c), 1'b0, '0);
        if (ph == 1 && n == 30) wait_drained();
        if (ph == 2 && n == 30) park_request = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d bus ticks sent, %0d checked: %0d probes, %0d writes, %0d reads, %0d with NACK",
             ticks_sent, results_checked, done_count[CMD_PROBE], done_count[CMD_WRITE],
             done_count[CMD_READ], nack_count);
    $display("half periods 0 to 2, device addresses 0x00 to 0xFF, commands while busy");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sccb_pkg.sv
hdl/sccb_seq.sv
hdl/sccb_register_master.sv
hdl/sccb_check.sv
sim/tb.sv
